// ----- rtl/bpa_pkg.sv -----
package bpa_pkg;

    // frame bitmap geometry
    localparam int PAGES      = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORD_SH    = 5;
    localparam int WORDS      = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W      = ($clog2(PAGES) > WORD_SH) ? $clog2(PAGES) : WORD_SH + 1;
    localparam int ADDR_W     = IDX_W - WORD_SH;
    localparam int CNT_W      = IDX_W + 1;
    localparam int LEN_W      = CNT_W + 1;

    // item field widths
    localparam int ACTION_W = 2;
    localparam int PFN_W    = 36;
    localparam int COUNT_W  = 16;
    localparam int BYTE_W   = 48;
    localparam int TYPE_W   = 32;
    localparam int STATUS_W = 2;

    // memory map arithmetic
    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int PGN_W = BYTE_W - PG_SH;
    localparam int CMP_W = ((PGN_W > PFN_W) ? PGN_W : PFN_W) + 2;

    // register port
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W   = PADDR_W - REG_IDX_LSB;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_PAGE = '0;
    localparam logic [PFN_W-1:0]     FIRST_PAGE_RST = PFN_W'(4096);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REGION = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd2;

    localparam logic [TYPE_W-1:0] REGION_USABLE = 32'd1;

    // scan unit answer for one bitmap word
    typedef struct packed {
        logic               hit;
        logic [WORD_SH-1:0] pos;
    } scan_res_t;

    // bit range being written, inclusive at both ends
    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] top;
        logic             val;
    } fill_rng_t;

endpackage

// ----- rtl/bpa_ram.sv -----
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bpa_scan.sv -----
module bpa_scan (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clr,
    input  logic                             step,
    input  logic [bpa_pkg::WORD_BITS-1:0]    used,
    input  logic [bpa_pkg::CNT_W-1:0]        count,
    output bpa_pkg::scan_res_t               res
);
    import bpa_pkg::*;

    logic [CNT_W-1:0]     run_reg;
    logic [CNT_W-1:0]     run_next;
    logic [WORD_BITS-1:0] upto [WORD_BITS];
    logic [LEN_W-1:0]     len [WORD_BITS];
    logic [WORD_BITS-1:0] hit_v;

    // index of the highest set bit
    function automatic logic [WORD_SH-1:0] msb_of(input logic [WORD_BITS-1:0] v);
        logic [WORD_SH-1:0] r;
        r = '0;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            if (v[k])
            begin
                r = WORD_SH'(k);
            end
        end
        return r;
    endfunction

    // free run length ending at each bit, carrying the run from earlier words
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            upto[j] = used & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - j));
            if (upto[j] == '0)
            begin
                len[j] = LEN_W'(run_reg) + LEN_W'(j + 1);
            end
            else
            begin
                len[j] = LEN_W'(WORD_SH'(j) - msb_of(upto[j]));
            end
            hit_v[j] = len[j] >= LEN_W'(count);
        end
    end

    // lowest bit where the run reaches the count
    always_comb
    begin
        res.hit = |hit_v;
        res.pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit_v[j])
            begin
                res.pos = WORD_SH'(j);
            end
        end
    end

    // run carried into the next word
    always_comb
    begin
        run_next = run_reg;
        if (clr)
        begin
            run_next = '0;
        end
        else if (step && !res.hit)
        begin
            run_next = len[WORD_BITS-1][CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

// ----- rtl/bpa_mask.sv -----
module bpa_mask (
    input  logic [bpa_pkg::ADDR_W-1:0]    word,
    input  bpa_pkg::fill_rng_t            rng,
    input  logic [bpa_pkg::WORD_BITS-1:0] rdata,
    output logic [bpa_pkg::WORD_BITS-1:0] wdata
);
    import bpa_pkg::*;

    logic [WORD_SH-1:0]   lo_off;
    logic [WORD_SH-1:0]   hi_off;
    logic [WORD_BITS-1:0] mask;

    // bits of this word that fall inside the range
    always_comb
    begin
        lo_off = (word == rng.lo[IDX_W-1:WORD_SH]) ? rng.lo[WORD_SH-1:0] : '0;
        hi_off = (word == rng.top[IDX_W-1:WORD_SH]) ? rng.top[WORD_SH-1:0] : '1;
        mask   = ({WORD_BITS{1'b1}} << lo_off) &
                 ({WORD_BITS{1'b1}} >> (WORD_SH'(WORD_BITS - 1) - hi_off));
        wdata  = rng.val ? (rdata | mask) : (rdata & ~mask);
    end

endmodule

// ----- rtl/bitmap_page_allocator_unit.sv -----
// bitmap page allocator: one used bit per page frame, 32 frames per memory word
// reset: a clearing pass marks all 1024 words used, input stalled until the pass ends
// accept to result: alloc scans words, then writes the run's words; with no free run it scans every word
// free and region write their range's words, except a free out of range or a region with nothing to free
// zero count, unusable region, unknown action, count above the frame total: result with no bitmap access
// one item at a time; the next is taken the cycle after its result enters the output register
module bitmap_page_allocator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // item in
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bpa_pkg::ACTION_W-1:0]      action,
    input  logic [bpa_pkg::PFN_W-1:0]         page,
    input  logic [bpa_pkg::COUNT_W-1:0]       page_count,
    input  logic [bpa_pkg::BYTE_W-1:0]        region_base,
    input  logic [bpa_pkg::BYTE_W-1:0]        region_length,
    input  logic [bpa_pkg::TYPE_W-1:0]        region_type,
    // result out
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bpa_pkg::STATUS_W-1:0]      status,
    output logic [bpa_pkg::PFN_W-1:0]         start_page,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bpa_pkg::PADDR_W-1:0]       paddr,
    input  logic [bpa_pkg::PDATA_W-1:0]       pwdata,
    output logic [bpa_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import bpa_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_SCAN   = 11'b000_0000_0100,
        S_FREE_A = 11'b000_0000_1000,
        S_FREE_B = 11'b000_0001_0000,
        S_REG_A  = 11'b000_0010_0000,
        S_REG_B  = 11'b000_0100_0000,
        S_REG_C  = 11'b000_1000_0000,
        S_REG_D  = 11'b001_0000_0000,
        S_FILL   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W:0]       rd_w_reg, rd_w_next;
    logic [ADDR_W-1:0]     last_w_reg, last_w_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_w_reg, pend_w_next;
    logic [PFN_W-1:0]      first_page_reg;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  res_ok_reg, res_ok_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [PFN_W-1:0]      out_start_reg, out_start_next;

    // item payload and working values
    logic [PFN_W-1:0]      page_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [BYTE_W-1:0]     base_reg;
    logic [BYTE_W-1:0]     length_reg;
    logic [CMP_W-1:0]      lo_reg, lo_next;
    logic [CMP_W-1:0]      hi_reg, hi_next;
    logic [CMP_W-1:0]      fp1_reg, fp1_next;
    logic [CMP_W-1:0]      top_reg, top_next;
    logic [IDX_W-1:0]      fill_lo_reg, fill_lo_next;
    logic [IDX_W-1:0]      fill_top_reg, fill_top_next;
    logic                  fill_val_reg, fill_val_next;

    logic                  issue;
    logic                  item_acc;
    logic                  out_take;
    logic                  cfg_wr;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      hit_lo;
    logic [IDX_W-1:0]      free_top;
    logic [IDX_W-1:0]      reg_lo_idx;
    logic [IDX_W-1:0]      reg_top_idx;
    logic [PGN_W-1:0]      base_pg;
    logic [PGN_W-1:0]      len_pg;
    logic                  rem_nz;

    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic [WORD_BITS-1:0]  mask_wdata;

    scan_res_t             scan_res;
    logic                  scan_clr;
    logic                  scan_step;
    fill_rng_t             fill_rng;

    // bitmap memory, one bit per frame, 1 = used
    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // first-fit run search, one word per cycle
    bpa_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (scan_clr),
        .step  (scan_step),
        .used  (ram_rdata),
        .count (CNT_W'(count_reg)),
        .res   (scan_res)
    );

    // word modify for the range fill
    assign fill_rng.lo  = fill_lo_reg;
    assign fill_rng.top = fill_top_reg;
    assign fill_rng.val = fill_val_reg;

    bpa_mask u_mask (
        .word  (pend_w_reg),
        .rng   (fill_rng),
        .rdata (ram_rdata),
        .wdata (mask_wdata)
    );

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign item_acc  = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign start_page = out_start_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[PADDR_W-1:REG_IDX_LSB] == REG_FIRST_PAGE);
    assign prdata = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_FIRST_PAGE) ?
                    PDATA_W'(first_page_reg) : '0;

    // address helpers
    assign issue       = rd_w_reg <= {1'b0, last_w_reg};
    assign hit_idx     = {pend_w_reg, scan_res.pos};
    assign hit_lo      = IDX_W'(CNT_W'(hit_idx) + CNT_W'(1) - CNT_W'(count_reg));
    assign free_top    = IDX_W'(lo_reg[IDX_W-1:0] + IDX_W'(count_reg) - IDX_W'(1));
    assign reg_lo_idx  = IDX_W'(lo_reg - CMP_W'(first_page_reg));
    assign reg_top_idx = IDX_W'(hi_reg - CMP_W'(first_page_reg) - CMP_W'(1));
    assign base_pg     = base_reg[BYTE_W-1:PG_SH];
    assign len_pg      = length_reg[BYTE_W-1:PG_SH];
    assign rem_nz      = |base_reg[PG_SH-1:0];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        rd_w_next       = rd_w_reg;
        last_w_next     = last_w_reg;
        pend_next       = pend_reg;
        pend_w_next     = pend_w_reg;
        res_status_next = res_status_reg;
        res_ok_next     = res_ok_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        fp1_next        = fp1_reg;
        top_next        = top_reg;
        fill_lo_next    = fill_lo_reg;
        fill_top_next   = fill_top_reg;
        fill_val_next   = fill_val_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = pend_w_reg;
        ram_raddr       = rd_w_reg[ADDR_W-1:0];
        ram_wdata       = mask_wdata;
        scan_clr        = 1'b0;
        scan_step       = 1'b0;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // mark every frame used after reset
            S_CLEAR:
            begin
                ram_we    = issue;
                ram_waddr = rd_w_reg[ADDR_W-1:0];
                ram_wdata = '1;
                if (issue)
                begin
                    rd_w_next = rd_w_reg + 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // take an item and sort out the early rejects
            S_IDLE:
            begin
                if (item_acc)
                begin
                    res_ok_next     = 1'b0;
                    res_status_next = STATUS_OK;
                    case (action)
                        ACT_ALLOC:
                        begin
                            if (page_count == '0)
                            begin
                                res_status_next = STATUS_BAD;
                                state_next      = S_DONE;
                            end
                            else if (32'(page_count) > 32'(PAGES))
                            begin
                                res_status_next = STATUS_NO_SPACE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                rd_w_next   = '0;
                                last_w_next = ADDR_W'(WORDS - 1);
                                pend_next   = 1'b0;
                                scan_clr    = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (page_count == '0)
                            begin
                                res_status_next = STATUS_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FREE_A;
                            end
                        end
                        ACT_REGION:
                        begin
                            state_next = (region_type == REGION_USABLE) ? S_REG_A : S_DONE;
                        end
                        default:
                        begin
                            res_status_next = STATUS_BAD;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            // first-fit scan, reads run one word ahead of the search
            S_SCAN:
            begin
                ram_re      = issue;
                pend_next   = issue;
                pend_w_next = rd_w_reg[ADDR_W-1:0];
                scan_step   = pend_reg;
                if (issue)
                begin
                    rd_w_next = rd_w_reg + 1'b1;
                end
                if (pend_reg && scan_res.hit)
                begin
                    fill_lo_next  = hit_lo;
                    fill_top_next = hit_idx;
                    fill_val_next = 1'b1;
                    rd_w_next     = {1'b0, hit_lo[IDX_W-1:WORD_SH]};
                    last_w_next   = pend_w_reg;
                    pend_next     = 1'b0;
                    res_ok_next   = 1'b1;
                    state_next    = S_FILL;
                end
                else if (!pend_reg && !issue)
                begin
                    res_status_next = STATUS_NO_SPACE;
                    state_next      = S_DONE;
                end
            end

            // offset of the freed run from the first tracked frame
            S_FREE_A:
            begin
                lo_next    = CMP_W'(page_reg) - CMP_W'(first_page_reg);
                state_next = S_FREE_B;
            end

            // range check of the freed run
            S_FREE_B:
            begin
                if (lo_reg[CMP_W-1] ||
                    ((lo_reg + CMP_W'(count_reg)) > CMP_W'(PAGES)))
                begin
                    res_status_next = STATUS_BAD;
                    state_next      = S_DONE;
                end
                else
                begin
                    fill_lo_next  = lo_reg[IDX_W-1:0];
                    fill_top_next = free_top;
                    fill_val_next = 1'b0;
                    rd_w_next     = {1'b0, lo_reg[IDX_W-1:WORD_SH]};
                    last_w_next   = free_top[IDX_W-1:WORD_SH];
                    pend_next     = 1'b0;
                    state_next    = S_FILL;
                end
            end

            // whole pages of the region: round base up, floor the length, drop a page if the base was rounded
            S_REG_A:
            begin
                lo_next    = CMP_W'(base_pg) + CMP_W'(rem_nz);
                hi_next    = CMP_W'(len_pg) - CMP_W'(rem_nz && (len_pg != '0));
                state_next = S_REG_B;
            end

            // region end and tracked window bounds
            S_REG_B:
            begin
                hi_next    = lo_reg + hi_reg;
                fp1_next   = CMP_W'(first_page_reg) + CMP_W'(1);
                top_next   = CMP_W'(first_page_reg) + CMP_W'(PAGES);
                state_next = S_REG_C;
            end

            // clip the region to the window
            S_REG_C:
            begin
                lo_next    = (lo_reg < fp1_reg) ? fp1_reg : lo_reg;
                hi_next    = (hi_reg > top_reg) ? top_reg : hi_reg;
                state_next = S_REG_D;
            end

            // convert to bit indexes, skip an empty range
            S_REG_D:
            begin
                if (lo_reg < hi_reg)
                begin
                    fill_lo_next  = reg_lo_idx;
                    fill_top_next = reg_top_idx;
                    fill_val_next = 1'b0;
                    rd_w_next     = {1'b0, reg_lo_idx[IDX_W-1:WORD_SH]};
                    last_w_next   = reg_top_idx[IDX_W-1:WORD_SH];
                    pend_next     = 1'b0;
                    state_next    = S_FILL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // read-modify-write one word per cycle, read runs one word ahead
            S_FILL:
            begin
                ram_re      = issue;
                pend_next   = issue;
                pend_w_next = rd_w_reg[ADDR_W-1:0];
                ram_we      = pend_reg;
                if (issue)
                begin
                    rd_w_next = rd_w_reg + 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_ok_reg ?
                                      (first_page_reg + PFN_W'(fill_lo_reg)) : '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            rd_w_reg       <= '0;
            last_w_reg     <= ADDR_W'(WORDS - 1);
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            first_page_reg <= FIRST_PAGE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rd_w_reg      <= rd_w_next;
            last_w_reg    <= last_w_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                first_page_reg <= pwdata[PFN_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            page_reg   <= page;
            count_reg  <= page_count;
            base_reg   <= region_base;
            length_reg <= region_length;
        end
        pend_w_reg     <= pend_w_next;
        res_status_reg <= res_status_next;
        res_ok_reg     <= res_ok_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        fp1_reg        <= fp1_next;
        top_reg        <= top_next;
        fill_lo_reg    <= fill_lo_next;
        fill_top_reg   <= fill_top_next;
        fill_val_reg   <= fill_val_next;
    end

    // the search only reads the bitmap
    a_scan_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("bitmap written during the run search");

    // the write-back never hits the word being read in the same cycle
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of the same bitmap word");

    // a fill range is never empty or reversed
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (fill_lo_reg <= fill_top_reg))
        else $error("fill range reversed");

    // a new result only comes out of the finishing step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the finishing step");

endmodule

// ----- bench/tb_bitmap_page_allocator_unit.sv -----
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_unit;
    import bpa_pkg::*;

    // one request item and the response it should produce
    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [PFN_W-1:0]    pg;
        logic [COUNT_W-1:0]  cnt;
        logic [BYTE_W-1:0]   base;
        logic [BYTE_W-1:0]   len;
        logic [TYPE_W-1:0]   rtype;
    } frame_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PFN_W-1:0]    start;
    } frame_resp_t;

    // a granted run, kept so that later items can hand it back
    typedef struct {
        int unsigned        idx;
        logic [COUNT_W-1:0] cnt;
    } frame_run_t;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [PFN_W-1:0]    PFN_MAX    = '1;
    localparam int                  IDLE_PCT   = 18;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action        = '0;
    logic [PFN_W-1:0]    page          = '0;
    logic [COUNT_W-1:0]  page_count    = '0;
    logic [BYTE_W-1:0]   region_base   = '0;
    logic [BYTE_W-1:0]   region_length = '0;
    logic [TYPE_W-1:0]   region_type   = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [PFN_W-1:0]    start_page;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // shadow of the frame bitmap and the first_page register
    bit                  frame_used [PAGES];
    logic [PFN_W-1:0]    fp_model = FIRST_PAGE_RST;
    frame_run_t          frame_runs [$];
    frame_resp_t         outcome_q [$];
    frame_resp_t         want;

    bit                  calm = 1'b0;
    int unsigned         fail_count   = 0;
    int unsigned         items_sent   = 0;
    int unsigned         results_seen = 0;
    int unsigned         cfg_writes   = 0;
    int unsigned         n_granted    = 0;
    int unsigned         n_no_space   = 0;
    int unsigned         n_rejected   = 0;

    bitmap_page_allocator_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .page          (page),
        .page_count    (page_count),
        .region_base   (region_base),
        .region_length (region_length),
        .region_type   (region_type),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .start_page    (start_page),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #(100_000_000);
        $display("bitmap_page_allocator_unit test failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // apply one item to the shadow bitmap and work out its response
    function automatic frame_resp_t frame_outcome(input frame_req_t req);
        frame_resp_t res;
        frame_run_t  got;
        logic [63:0] fp, off, rem, abase, np, lo, hi, top, p;
        int          run, last;
        bit          hit;
        fp = 64'(fp_model);
        res.status = STATUS_OK;
        res.start = '0;
        case (req.act)
            ACT_ALLOC:
            begin
                if (req.cnt == 0)
                    res.status = STATUS_BAD;
                else
                begin
                    // first fit: lowest run of free frames
                    run = 0;
                    hit = 1'b0;
                    last = 0;
                    for (int i = 0; i < PAGES && !hit; i++)
                    begin
                        if (!frame_used[i])
                        begin
                            run++;
                            if (run == req.cnt)
                            begin
                                hit = 1'b1;
                                last = i;
                            end
                        end
                        else
                            run = 0;
                    end
                    if (hit)
                    begin
                        got.idx = last + 1 - req.cnt;
                        got.cnt = req.cnt;
                        for (int k = 0; k < req.cnt; k++)
                            frame_used[got.idx + k] = 1'b1;
                        res.start = PFN_W'(fp + got.idx);
                        frame_runs.push_back(got);
                    end
                    else
                        res.status = STATUS_NO_SPACE;
                end
            end
            ACT_FREE:
            begin
                off = 64'(req.pg) - fp;
                if (req.cnt == 0 || 64'(req.pg) < fp || off + req.cnt > PAGES)
                    res.status = STATUS_BAD;
                else
                    for (int k = 0; k < req.cnt; k++)
                        frame_used[off + k] = 1'b0;
            end
            ACT_REGION:
            begin
                if (req.rtype == REGION_USABLE)
                begin
                    // whole pages only, bit zero frame stays used
                    rem = req.base % PAGE_BYTES;
                    abase = (rem != 0) ? 64'(req.base) + (PAGE_BYTES - rem) : 64'(req.base);
                    np = 64'(req.len) / PAGE_BYTES;
                    if (rem != 0 && np != 0)
                        np--;
                    lo = abase / PAGE_BYTES;
                    hi = lo + np;
                    if (lo < fp + 1)
                        lo = fp + 1;
                    top = fp + PAGES;
                    if (hi > top)
                        hi = top;
                    for (p = lo; p < hi; p++)
                        frame_used[p - fp] = 1'b0;
                end
            end
            default:
                res.status = STATUS_BAD;
        endcase
        if (req.act == ACT_ALLOC && res.status == STATUS_OK)
            n_granted++;
        else if (res.status == STATUS_NO_SPACE)
            n_no_space++;
        else if (res.status == STATUS_BAD)
            n_rejected++;
        return res;
    endfunction

    // drive one item and hold it until taken
    task automatic send_req(input logic [ACTION_W-1:0] act, input logic [PFN_W-1:0] pg,
                            input logic [COUNT_W-1:0] cnt, input logic [BYTE_W-1:0] base,
                            input logic [BYTE_W-1:0] len, input logic [TYPE_W-1:0] rtype);
        frame_req_t req;
        req.act = act;
        req.pg = pg;
        req.cnt = cnt;
        req.base = base;
        req.len = len;
        req.rtype = rtype;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        page          <= pg;
        page_count    <= cnt;
        region_base   <= base;
        region_length <= len;
        region_type   <= rtype;
        do
            @(posedge clk);
        while (in_stall);
        outcome_q.push_back(frame_outcome(req));
        items_sent++;
    endtask

    // stop sending and let every pending response come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_first_page(input logic [PFN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FIRST_PAGE, {REG_IDX_LSB{1'b0}}};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fp_model = value;
        cfg_writes++;
    endtask

    // everything used after reset, zero counts, unknown action, unusable regions
    task automatic test_reset_state();
        logic [BYTE_W-1:0] b0;
        b0 = BYTE_W'(64'(fp_model) * PAGE_BYTES);
        send_req(ACT_ALLOC, '0, 16'd1, '0, '0, '0);
        send_req(ACT_ALLOC, '0, 16'd0, '0, '0, '0);
        send_req(ACT_FREE, fp_model, 16'd0, '0, '0, '0);
        send_req(ACT_UNUSED, PFN_MAX, '1, '1, '1, '1);
        send_req(ACT_REGION, '0, '0, b0, BYTE_W'(PAGES * PAGE_BYTES), 32'd0);
        send_req(ACT_REGION, '0, '0, b0, BYTE_W'(PAGES * PAGE_BYTES), '1);
        send_req(ACT_ALLOC, '0, 16'd1, '0, '0, '0);
    endtask

    // region rounding and clipping, full-map runs, range edges of free
    task automatic test_region_bounds();
        logic [BYTE_W-1:0] b0;
        b0 = BYTE_W'(64'(fp_model) * PAGE_BYTES);
        send_req(ACT_REGION, '0, '0, b0, BYTE_W'(PAGES * PAGE_BYTES), REGION_USABLE);
        send_req(ACT_ALLOC, '0, 16'd1, '0, '0, '0);
        send_req(ACT_FREE, fp_model, 16'd1, '0, '0, '0);
        send_req(ACT_ALLOC, '0, 16'd1, '0, '0, '0);
        send_req(ACT_ALLOC, '0, 16'(PAGES), '0, '0, '0);
        send_req(ACT_FREE, fp_model, 16'(PAGES), '0, '0, '0);
        send_req(ACT_ALLOC, '0, 16'(PAGES), '0, '0, '0);
        send_req(ACT_ALLOC, '0, 16'd1, '0, '0, '0);
        send_req(ACT_FREE, PFN_W'(fp_model + PAGES - 1), 16'd1, '0, '0, '0);
        send_req(ACT_FREE, PFN_W'(fp_model + PAGES - 1), 16'd2, '0, '0, '0);
        send_req(ACT_FREE, PFN_W'(fp_model - 1), 16'd1, '0, '0, '0);
        send_req(ACT_ALLOC, '0, '1, '0, '0, '0);
        // unaligned base loses a page
        send_req(ACT_REGION, '0, '0, BYTE_W'(b0 + 100 * PAGE_BYTES + 1),
                 BYTE_W'(8 * PAGE_BYTES + 5), REGION_USABLE);
        // region starting below the tracked range
        send_req(ACT_REGION, '0, '0, '0, BYTE_W'((64'(fp_model) + 3) * PAGE_BYTES),
                 REGION_USABLE);
        // region running past the top
        send_req(ACT_REGION, '0, '0, BYTE_W'(b0 + (PAGES - 2) * PAGE_BYTES),
                 BYTE_W'(16 * PAGE_BYTES), REGION_USABLE);
        send_req(ACT_ALLOC, '0, 16'd7, '0, '0, '0);
    endtask

    // first_page at zero and at its maximum, start page wrapping
    task automatic test_first_page_extremes();
        wait_drained();
        write_first_page('0);
        send_req(ACT_FREE, '0, 16'(PAGES), '0, '0, '0);
        send_req(ACT_ALLOC, '0, 16'd5, '0, '0, '0);
        send_req(ACT_REGION, '0, '0, '0, BYTE_W'(10 * PAGE_BYTES), REGION_USABLE);
        wait_drained();
        write_first_page(PFN_MAX);
        send_req(ACT_ALLOC, '0, 16'd1, '0, '0, '0);
        send_req(ACT_FREE, PFN_MAX, 16'd1, '0, '0, '0);
        send_req(ACT_FREE, PFN_MAX, 16'(PAGES + 1), '0, '0, '0);
        send_req(ACT_REGION, '0, '0, '1, '1, REGION_USABLE);
        send_req(ACT_ALLOC, '0, 16'd1, '0, '0, '0);
    endtask

    // one setting of first_page with a random mix of items
    task automatic random_phase(input logic [PFN_W-1:0] fp_val, input int n_items,
                                input bit quiet, input bit pause_mid);
        frame_req_t req;
        frame_run_t r;
        logic [63:0] bp;
        int pick, sz, ri;
        wait_drained();
        write_first_page(fp_val);
        calm = quiet;
        for (int n = 0; n < n_items; n++)
        begin
            if (pause_mid && n == n_items / 2)
                wait_drained();
            req.act = ACT_ALLOC;
            req.pg = PFN_W'(rand64());
            req.cnt = COUNT_W'($urandom());
            req.base = BYTE_W'(rand64());
            req.len = BYTE_W'(rand64());
            req.rtype = $urandom();
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                // mostly small runs, a few that scan far
                sz = $urandom_range(99);
                req.cnt = COUNT_W'((sz < 85) ? $urandom_range(1, 16) :
                          (sz < 97) ? $urandom_range(17, 600) : $urandom_range(601, 40000));
            end
            else if (pick < 65)
            begin
                req.act = ACT_FREE;
                if (frame_runs.size() != 0 && $urandom_range(99) < 80)
                begin
                    ri = $urandom_range(frame_runs.size() - 1);
                    r = frame_runs[ri];
                    frame_runs.delete(ri);
                    req.pg = PFN_W'(64'(fp_model) + 64'(r.idx));
                    req.cnt = COUNT_W'(($urandom_range(3) == 0) ?
                                       $urandom_range(1, r.cnt) : 32'(r.cnt));
                end
                else
                begin
                    req.pg = PFN_W'(64'(fp_model) + 64'($urandom_range(0, PAGES + 8)));
                    req.cnt = COUNT_W'($urandom_range(0, 48));
                    if ($urandom_range(9) == 0)
                        req.pg = PFN_W'(64'(fp_model) - 64'($urandom_range(1, 8)));
                end
            end
            else if (pick < 80)
            begin
                // memory map entry near the tracked range
                req.act = ACT_REGION;
                req.rtype = ($urandom_range(9) == 0) ? $urandom() : REGION_USABLE;
                bp = 64'(fp_model) + 64'($urandom_range(0, PAGES + 64)) -
                     64'($urandom_range(0, 64));
                req.base = BYTE_W'(bp * PAGE_BYTES +
                           64'($urandom_range(1) ? $urandom_range(1, PAGE_BYTES - 1) : 0));
                req.len = BYTE_W'(64'($urandom_range(0, 320)) * PAGE_BYTES +
                          64'($urandom_range(1) ? $urandom_range(0, PAGE_BYTES - 1) : 0));
                if ($urandom_range(29) == 0)
                    req.len = BYTE_W'(64'(PAGES + 2) * PAGE_BYTES);
            end
            else
            begin
                // noise: every field random
                req.act = ACTION_W'($urandom_range(3));
                if (req.act == ACT_REGION && $urandom_range(1))
                    req.rtype = REGION_USABLE;
            end
            send_req(req.act, req.pg, req.cnt, req.base, req.len, req.rtype);
        end
        calm = 1'b0;
    endtask

    // several first_page settings, one phase with no idling, one with a drain pause
    task automatic test_random_traffic();
        random_phase(FIRST_PAGE_RST, 140, 1'b1, 1'b0);
        random_phase(PFN_W'(rand64()), 140, 1'b0, 1'b0);
        random_phase('0, 140, 1'b0, 1'b1);
        random_phase(PFN_W'(64'(PFN_MAX) - 64'($urandom_range(0, 40000))), 140, 1'b0, 1'b0);
        random_phase(PFN_W'($urandom_range(1, 1 << 20)), 140, 1'b0, 1'b0);
    endtask

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    // compare each response against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("response with nothing pending: status %0d start_page %0h",
                       status, start_page);
                fail_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                results_seen++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (start_page !== want.start)
                begin
                    $error("start_page: expected %0h, actual %0h", want.start, start_page);
                    fail_count++;
                end
            end
        end
    end

    // sequence of tests
    initial
    begin
        for (int i = 0; i < PAGES; i++)
            frame_used[i] = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_region_bounds();
        test_first_page_extremes();
        test_random_traffic();
        wait_drained();
        repeat (2200) @(posedge clk);
        $display("%0d items over %0d first_page writes: %0d runs granted, %0d no space, %0d rejected",
                 items_sent, cfg_writes, n_granted, n_no_space, n_rejected);
        $display("%0d responses compared, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0)
            $display("bitmap_page_allocator_unit test passed");
        else
            $display("bitmap_page_allocator_unit test failed");
        $finish;
    end

endmodule
